>>> design/crld_pkg.sv
package crld_pkg;

  localparam int MAP_BYTES = 4096;
  localparam int POS_W = $clog2(MAP_BYTES) + 1;

  localparam int OFFSET_W = 12;
  localparam int VALUE_W = 8;
  localparam int LENGTH_W = 7;
  localparam int OUT_DATA_W = 32;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [VALUE_W-1:0]  value;
    logic [LENGTH_W-1:0] length;
    logic                clamped;
    logic                map_done;
  } desc_t;

  typedef struct packed {
    logic  push;
    desc_t data;
  } push_req_t;

endpackage

>>> design/copy_fill_rle_decoder.sv
// Copy/fill run-length decoder.
// s_axis takes the compressed stream one byte per request (tdata[7:0]).
// A header byte holds the count in bits 6..0 and the mode in bit 7
// (0 copy, 1 fill); a zero count is skipped. Copy payload bytes come out
// one descriptor each with length 1; a fill value byte comes out as one
// descriptor of the whole length.
// m_axis carries one write descriptor per request: tdata holds offset,
// value and length, tuser flags a packet cut at the map end, tlast marks
// the descriptor that completes the map. The next byte then starts a map.
// Throughput: one byte per cycle while the queue is not full (s_axis_tready
// high). A descriptor is written into a two-entry queue when its byte is
// taken, then moved to the output register that drives m_axis.
// While m_axis is stalled, the queue absorbs two more descriptors before
// s_axis_tready drops; header bytes are taken as long as the queue has room.
// Reset clears the parse state, queue and output valid; the first byte
// after reset is a header at map position 0.
module copy_fill_rle_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] in_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [crld_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [11:0] write_offset,
                                                           // [19:12] write_value,
                                                           // [26:20] write_length
  output logic                            m_axis_tuser,   // [0] clamped
  output logic                            m_axis_tlast    // map_done
);
  import crld_pkg::*;

  push_req_t req;
  logic      full;
  logic      empty;
  logic      pop;
  desc_t     head;

  crld_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_byte  (s_axis_tdata),
    .in_ready (s_axis_tready),
    .full     (full),
    .req      (req)
  );

  crld_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .full  (full),
    .pop   (pop),
    .empty (empty),
    .head  (head)
  );

  crld_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(req.push && full))
    else $error("descriptor pushed into full queue");

  a_length_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[26:20] != 7'd0)
    else $error("descriptor with zero length");

  a_done_matches_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast ==
      ((13'(m_axis_tdata[11:0]) + 13'(m_axis_tdata[26:20])) >= 13'(MAP_BYTES))))
    else $error("map_done does not match descriptor end");

endmodule

>>> design/crld_front.sv
module crld_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  output logic                 in_ready,
  input  logic                 full,
  output crld_pkg::push_req_t  req
);
  import crld_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_COPY   = 2'd1;
  localparam logic [1:0] PH_FILL   = 2'd2;

  logic [1:0]          parse_phase, parse_phase_next;
  logic [LENGTH_W-1:0] bytes_left, bytes_left_next;
  logic [POS_W-1:0]    out_position, out_position_next;
  logic                packet_clamped, packet_clamped_next;

  logic                accept;
  logic [LENGTH_W-1:0] em_len;
  logic [POS_W-1:0]    em_end;
  logic                em_done;
  logic [POS_W-1:0]    em_pos_next;
  logic [LENGTH_W-1:0] count;
  logic [POS_W-1:0]    pos_eff;
  logic [POS_W-1:0]    room;
  logic                over;

  assign in_ready = !full;
  assign accept = in_valid && in_ready;

  assign em_len = (parse_phase == PH_FILL) ? bytes_left : LENGTH_W'(1);
  assign em_end = out_position + POS_W'(em_len);
  assign em_done = em_end >= POS_W'(MAP_BYTES);
  assign em_pos_next = em_done ? '0 : em_end;

  assign count = in_byte[LENGTH_W-1:0];
  assign pos_eff = (out_position >= POS_W'(MAP_BYTES)) ? '0 : out_position;
  assign room = POS_W'(MAP_BYTES) - pos_eff;
  assign over = POS_W'(count) > room;

  always_comb begin
    parse_phase_next = parse_phase;
    bytes_left_next = bytes_left;
    out_position_next = out_position;
    packet_clamped_next = packet_clamped;
    req.push = 1'b0;
    req.data.offset = out_position[OFFSET_W-1:0];
    req.data.value = in_byte;
    req.data.length = em_len;
    req.data.clamped = packet_clamped;
    req.data.map_done = em_done;
    if (accept) begin
      case (parse_phase)
        PH_COPY: begin
          req.push = 1'b1;
          out_position_next = em_pos_next;
          bytes_left_next = bytes_left - LENGTH_W'(1);
          if (bytes_left_next == '0 || em_pos_next == '0) begin
            parse_phase_next = PH_HEADER;
          end
        end
        PH_FILL: begin
          req.push = 1'b1;
          out_position_next = em_pos_next;
          bytes_left_next = '0;
          parse_phase_next = PH_HEADER;
        end
        default: begin
          parse_phase_next = PH_HEADER;
          if (count != '0) begin
            out_position_next = pos_eff;
            packet_clamped_next = over;
            bytes_left_next = over ? room[LENGTH_W-1:0] : count;
            parse_phase_next = in_byte[7] ? PH_FILL : PH_COPY;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_HEADER;
      bytes_left <= '0;
      out_position <= '0;
      packet_clamped <= 1'b0;
    end else begin
      parse_phase <= parse_phase_next;
      bytes_left <= bytes_left_next;
      out_position <= out_position_next;
      packet_clamped <= packet_clamped_next;
    end
  end

endmodule

>>> design/crld_fifo.sv
module crld_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  crld_pkg::push_req_t  req,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output crld_pkg::desc_t      head
);
  import crld_pkg::*;

  desc_t                 mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] fill;
  logic                  do_push;
  logic                  do_pop;

  assign full = fill == FIFO_CNT_W'(FIFO_DEPTH);
  assign empty = fill == '0;
  assign do_push = req.push && !full;
  assign do_pop = pop && !empty;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + FIFO_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + FIFO_CNT_W'(1);
        2'b01:   fill <= fill - FIFO_CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> design/crld_back.sv
module crld_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           empty,
  input  crld_pkg::desc_t                head,
  output logic                           pop,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [crld_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);
  import crld_pkg::*;

  localparam int PAD_W = OUT_DATA_W - OFFSET_W - VALUE_W - LENGTH_W;

  logic load;

  assign load = !m_axis_tvalid || m_axis_tready;
  assign pop = load && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_axis_tdata <= {{PAD_W{1'b0}}, head.length, head.value, head.offset};
      m_axis_tuser <= head.clamped;
      m_axis_tlast <= head.map_done;
    end
  end

endmodule
